// ===== src/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg
// shared types and status codes for the stable priority queue
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int PRIO_W   = 8;
  localparam int TAG_W    = 16;
  localparam int STATUS_W = 2;
  localparam int OCC_W    = 5;

  typedef enum logic [STATUS_W-1:0] {
    ST_ENQ   = 2'd0,
    ST_DEQ   = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  // one stored entry of the sorted chain
  typedef struct packed {
    logic              valid;
    logic [PRIO_W-1:0] prio;
    logic [TAG_W-1:0]  tag;
  } entry_t;

  // command broadcast to every cell
  typedef struct packed {
    logic              enq;
    logic              deq;
    logic [PRIO_W-1:0] prio;
    logic [TAG_W-1:0]  tag;
  } ctrl_t;

endpackage

// ===== src/spq_cell.sv =====
// ----------------------------------------------------------------------------
// spq_cell
// one slot of the sorted chain: keep, take the new entry, or take a neighbor
// ----------------------------------------------------------------------------
module spq_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  spq_pkg::ctrl_t ctrl,
  input  spq_pkg::entry_t left_ent,
  input  logic           left_flag,
  input  spq_pkg::entry_t right_ent,
  output spq_pkg::entry_t ent,
  output logic           flag
);

  logic                       valid_r, valid_nxt;
  logic [spq_pkg::PRIO_W-1:0] prio_r, prio_nxt;
  logic [spq_pkg::TAG_W-1:0]  tag_r, tag_nxt;

  // new entry belongs at or before this slot; equal priority goes behind
  assign flag = !valid_r || (ctrl.prio > prio_r);

  always_comb begin
    valid_nxt = valid_r;
    prio_nxt  = prio_r;
    tag_nxt   = tag_r;
    if (ctrl.deq) begin
      valid_nxt = right_ent.valid;
      prio_nxt  = right_ent.prio;
      tag_nxt   = right_ent.tag;
    end else if (ctrl.enq && flag) begin
      if (left_flag) begin
        valid_nxt = left_ent.valid;
        prio_nxt  = left_ent.prio;
        tag_nxt   = left_ent.tag;
      end else begin
        valid_nxt = 1'b1;
        prio_nxt  = ctrl.prio;
        tag_nxt   = ctrl.tag;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prio_r <= prio_nxt;
    tag_r  <= tag_nxt;
  end

  assign ent = '{valid: valid_r, prio: prio_r, tag: tag_r};

endmodule

// ===== src/stable_priority_queue.sv =====
// ----------------------------------------------------------------------------
// stable_priority_queue
// bounded priority queue, highest priority first, arrival order among equals
// ----------------------------------------------------------------------------
//  channel  direction  handshake          payload
//  in       input      in_valid/in_stall  in_cmd, in_prio, in_tag
//  out      output     out_valid/out_stall out_status, out_prio, out_tag,
//                                          out_occupancy
//
//  one transaction per cycle while in_stall is low: the chain of cells
//  inserts or pops in a single step with purely local compares
//  the result of each accepted command is loaded into an output register
//  in_stall is high only while a result waits and out_stall holds it
//  synchronous active-low reset empties the chain (valid bits and count)
// ----------------------------------------------------------------------------
module stable_priority_queue #(
  parameter int CAPACITY = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_cmd,
  input  logic [spq_pkg::PRIO_W-1:0]  in_prio,
  input  logic [spq_pkg::TAG_W-1:0]   in_tag,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [spq_pkg::STATUS_W-1:0] out_status,
  output logic [spq_pkg::PRIO_W-1:0]  out_prio,
  output logic [spq_pkg::TAG_W-1:0]   out_tag,
  output logic [spq_pkg::OCC_W-1:0]   out_occupancy
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  // chain wiring, cell 0 holds the entry served next
  spq_pkg::entry_t cell_ent  [CAPACITY];
  logic            cell_flag [CAPACITY];
  spq_pkg::ctrl_t  ctrl;

  logic [CNT_W-1:0] count_r, count_nxt;
  logic             full, empty, accept;

  logic                         out_valid_r;
  spq_pkg::status_t             status_r, status_nxt;
  logic [spq_pkg::PRIO_W-1:0]   prio_r, prio_nxt;
  logic [spq_pkg::TAG_W-1:0]    tag_r, tag_nxt;
  logic [spq_pkg::OCC_W-1:0]    occ_r;
  logic [CNT_W+spq_pkg::OCC_W-1:0] occ_ext;

  // a new transaction enters unless a result is stuck in the output register
  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  assign full  = (count_r == CAP_CNT);
  assign empty = (count_r == '0);

  // refused commands never reach the cells
  assign ctrl.enq  = accept && !in_cmd && !full;
  assign ctrl.deq  = accept && in_cmd && !empty;
  assign ctrl.prio = in_prio;
  assign ctrl.tag  = in_tag;

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      spq_pkg::entry_t left_ent, right_ent;
      logic            left_flag;

      if (g == 0) begin : g_head
        assign left_ent  = '0;
        assign left_flag = 1'b0;
      end else begin : g_mid
        assign left_ent  = cell_ent[g-1];
        assign left_flag = cell_flag[g-1];
      end

      if (g == CAPACITY - 1) begin : g_tail
        assign right_ent = '0;
      end else begin : g_body
        assign right_ent = cell_ent[g+1];
      end

      spq_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .left_ent  (left_ent),
        .left_flag (left_flag),
        .right_ent (right_ent),
        .ent       (cell_ent[g]),
        .flag      (cell_flag[g])
      );
    end
  endgenerate

  // next count and the result of the command being accepted
  always_comb begin
    count_nxt  = count_r;
    status_nxt = spq_pkg::ST_ENQ;
    prio_nxt   = '0;
    tag_nxt    = '0;
    if (in_cmd) begin
      if (empty) begin
        status_nxt = spq_pkg::ST_EMPTY;
      end else begin
        status_nxt = spq_pkg::ST_DEQ;
        prio_nxt   = cell_ent[0].prio;
        tag_nxt    = cell_ent[0].tag;
        count_nxt  = count_r - 1'b1;
      end
    end else begin
      if (full) begin
        status_nxt = spq_pkg::ST_FULL;
      end else begin
        count_nxt = count_r + 1'b1;
      end
    end
  end

  // occupancy field is the low bits of the count, zero-extended when narrower
  assign occ_ext = {{spq_pkg::OCC_W{1'b0}}, count_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload, loaded only with a new transaction
  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
      prio_r   <= prio_nxt;
      tag_r    <= tag_nxt;
      occ_r    <= occ_ext[spq_pkg::OCC_W-1:0];
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = status_r;
  assign out_prio      = prio_r;
  assign out_tag       = tag_r;
  assign out_occupancy = occ_r;

endmodule

// ===== tb/stable_priority_queue_tb.sv =====
// ----------------------------------------------------------------------------
// stable_priority_queue_tb
// self-checking bench for the bounded priority queue with arrival-order ties
//
// a queue of pending commands feeds a clocked driver, and a clocked monitor
// checks every result against a shadow queue kept in arrival order. Both
// channels idle in random bursts, the receiver once holds off long enough to
// back up the input, and the tail of the run flows without gaps.
// ----------------------------------------------------------------------------
module stable_priority_queue_tb;

  localparam int CAPACITY       = 16;
  localparam int CLK_PERIOD     = 10;
  localparam int RESET_CYCLES   = 7;
  localparam int RANDOM_ITEMS   = 1200;
  localparam int PRESSURE_AT    = 480;     // random item where the enqueue run goes in
  localparam int PRESSURE_RUN   = 24;      // enqueues in that run, more than the capacity
  localparam int HOLD_CYCLES    = 80;      // length of the long receiver hold-off
  localparam int TAIL_ITEMS     = 150;     // last stretch of the run goes without idling
  localparam int DRAIN_CYCLES   = 8;       // margin after the last result
  localparam int TIMEOUT_CYCLES = 400000;
  localparam int REPORT_LIMIT   = 10;

  localparam logic CMD_ENQ = 1'b0;
  localparam logic CMD_DEQ = 1'b1;

  typedef struct {
    logic                       cmd;
    logic [spq_pkg::PRIO_W-1:0] prio;
    logic [spq_pkg::TAG_W-1:0]  tag;
  } command_t;

  typedef struct {
    spq_pkg::status_t           status;
    logic [spq_pkg::PRIO_W-1:0] prio;
    logic [spq_pkg::TAG_W-1:0]  tag;
    logic [spq_pkg::OCC_W-1:0]  occ;
  } outcome_t;

  logic                         clk           = 1'b0;
  logic                         rst_n         = 1'b0;
  logic                         in_valid      = 1'b0;
  logic                         in_cmd        = CMD_ENQ;
  logic [spq_pkg::PRIO_W-1:0]   in_prio       = '0;
  logic [spq_pkg::TAG_W-1:0]    in_tag        = '0;
  logic                         out_stall     = 1'b0;
  logic                         in_stall;
  logic                         out_valid;
  logic [spq_pkg::STATUS_W-1:0] out_status;
  logic [spq_pkg::PRIO_W-1:0]   out_prio;
  logic [spq_pkg::TAG_W-1:0]    out_tag;
  logic [spq_pkg::OCC_W-1:0]    out_occupancy;

  command_t        pending_q[$];    // commands not yet offered
  outcome_t        awaited_q[$];    // predicted results, oldest first
  spq_pkg::entry_t shadow_q[$];     // entries held by the block, in arrival order

  int accepted_n     = 0;
  int results_n      = 0;
  int errors         = 0;
  int in_stalled_n   = 0;
  int status_seen[4] = '{0, 0, 0, 0};
  int pressure_index = 0;
  int send_gap       = 0;
  int recv_gap       = 0;
  int send_idle_pct  = 0;
  int recv_idle_pct  = 0;
  logic hold_req     = 1'b0;

  stable_priority_queue #(
    .CAPACITY(CAPACITY)
  ) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_cmd       (in_cmd),
    .in_prio      (in_prio),
    .in_tag       (in_tag),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_status   (out_status),
    .out_prio     (out_prio),
    .out_tag      (out_tag),
    .out_occupancy(out_occupancy)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // shadow of the queue: enqueue appends, dequeue takes the first of the
  // highest priority, so a strict compare keeps the earliest arrival
  function automatic outcome_t serve_command(logic cmd,
                                             logic [spq_pkg::PRIO_W-1:0] prio,
                                             logic [spq_pkg::TAG_W-1:0] tag);
    outcome_t r;
    int best;
    r = '{status: spq_pkg::ST_ENQ, prio: '0, tag: '0, occ: '0};
    if (cmd == CMD_ENQ) begin
      if (shadow_q.size() >= CAPACITY) begin
        r.status = spq_pkg::ST_FULL;      // refused, nothing changes
      end else begin
        shadow_q.push_back('{valid: 1'b1, prio: prio, tag: tag});
      end
    end else if (shadow_q.size() == 0) begin
      r.status = spq_pkg::ST_EMPTY;
    end else begin
      best = 0;
      for (int i = 1; i < shadow_q.size(); i++) begin
        if (shadow_q[i].prio > shadow_q[best].prio) best = i;
      end
      r.status = spq_pkg::ST_DEQ;
      r.prio   = shadow_q[best].prio;
      r.tag    = shadow_q[best].tag;
      shadow_q.delete(best);
    end
    r.occ = spq_pkg::OCC_W'(shadow_q.size());
    return r;
  endfunction

  task automatic queue_cmd(logic cmd, logic [spq_pkg::PRIO_W-1:0] prio,
                           logic [spq_pkg::TAG_W-1:0] tag);
    pending_q.push_back('{cmd: cmd, prio: prio, tag: tag});
  endtask

  // idle intensity for both sides is redrawn periodically from a set of levels, zero
  // included, so there are quiet stretches as well as choppy ones
  always @(posedge clk) begin : idle_mode
    int cyc;
    int modes[4];
    modes = '{0, 5, 25, 60};
    if (cyc % 48 == 0) begin
      send_idle_pct <= modes[$urandom_range(0, 3)];
      recv_idle_pct <= modes[$urandom_range(0, 3)];
    end
    cyc++;
  end

  // driver: a held transaction stays put until taken, gaps only start
  // between transactions, so valid never drops while stalled
  always @(posedge clk) begin : drive
    logic     take;
    logic     calm;
    command_t c;
    take = in_valid && !in_stall;
    calm = (pending_q.size() < TAIL_ITEMS) || hold_req;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (take) begin
        awaited_q.push_back(serve_command(in_cmd, in_prio, in_tag));
        accepted_n++;
      end
      if (in_valid && in_stall) begin
        in_stalled_n++;                // block pushed back, keep offering
      end else if (send_gap > 0) begin
        in_valid <= 1'b0;
        send_gap--;
      end else if (pending_q.size() == 0) begin
        in_valid <= 1'b0;
      end else if (!calm && $urandom_range(0, 99) < send_idle_pct) begin
        in_valid <= 1'b0;
        send_gap = $urandom_range(1, 19) - 1;
      end else begin
        c = pending_q.pop_front();
        in_valid <= 1'b1;
        in_cmd   <= c.cmd;
        in_prio  <= c.prio;
        in_tag   <= c.tag;
      end
    end
  end

  // receiver stall: random bursts, or the long hold-off when requested
  always @(posedge clk) begin : stall_drive
    logic calm;
    calm = (pending_q.size() < TAIL_ITEMS);
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_req) begin
      out_stall <= 1'b1;
    end else if (recv_gap > 0) begin
      out_stall <= 1'b1;
      recv_gap--;
    end else if (!calm && $urandom_range(0, 99) < recv_idle_pct) begin
      out_stall <= 1'b1;
      recv_gap = $urandom_range(1, 19) - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // long hold-off, timed in its own process, lands on the enqueue run so
  // the output register fills and the input backs up
  initial begin : long_hold
    while (pressure_index == 0 || accepted_n < pressure_index + 4) @(posedge clk);
    hold_req <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_req <= 1'b0;
  end

  // monitor: every result transaction against the oldest prediction
  always @(posedge clk) begin : check
    outcome_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_n++;
      status_seen[out_status]++;
      if (awaited_q.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("mismatch: result with nothing pending, st %0d p %0d t %h o %0d",
                   out_status, out_prio, out_tag, out_occupancy);
      end else begin
        want = awaited_q.pop_front();
        if (out_status !== want.status || out_prio !== want.prio ||
            out_tag !== want.tag || out_occupancy !== want.occ) begin
          errors++;
          if (errors <= REPORT_LIMIT)
            $display({"mismatch at result %0d: expected st %0d p %0d t %h o %0d,",
                      " got st %0d p %0d t %h o %0d"},
                     results_n, want.status, want.prio, want.tag, want.occ,
                     out_status, out_prio, out_tag, out_occupancy);
        end
      end
    end
  end

  initial begin : stimulus
    int       made;
    int       phase_len;
    int       enq_pct;
    logic     narrow;
    int       bias[3];
    bias = '{80, 20, 50};

    // directed: dequeue from empty with all-ones payload that must be ignored
    queue_cmd(CMD_DEQ, 8'hff, 16'hffff);
    // two entries of top priority, the earlier one must come out first
    queue_cmd(CMD_ENQ, 8'hff, 16'hffff);
    queue_cmd(CMD_ENQ, 8'hff, 16'h0001);
    queue_cmd(CMD_DEQ, 8'h00, 16'h0000);
    queue_cmd(CMD_DEQ, 8'h00, 16'h0000);
    // queue is empty again, this dequeue must report empty, then refill to capacity
    queue_cmd(CMD_DEQ, 8'h00, 16'h0000);
    for (int i = 0; i < CAPACITY; i++) begin
      queue_cmd(CMD_ENQ, (i == 0) ? 8'h00 : (i == CAPACITY - 1) ? 8'hff : 8'(i % 3),
                (i == 0) ? 16'h0000 : (i == 1) ? 16'hffff : 16'(16'ha5a5 ^ i));
    end
    // one past capacity is refused
    queue_cmd(CMD_ENQ, 8'h80, 16'h5a5a);

    // random phases: fill-heavy, drain-heavy or balanced, with either a
    // narrow priority range for many ties or the full range
    made = 0;
    while (made < RANDOM_ITEMS) begin
      phase_len = $urandom_range(8, 64);
      enq_pct   = bias[$urandom_range(0, 2)];
      narrow    = 1'($urandom_range(0, 1));
      for (int k = 0; k < phase_len && made < RANDOM_ITEMS; k++) begin
        if (made == PRESSURE_AT) begin
          pressure_index = pending_q.size();
          for (int j = 0; j < PRESSURE_RUN; j++)
            queue_cmd(CMD_ENQ, 8'($urandom), 16'($urandom));
        end
        queue_cmd(($urandom_range(0, 99) < enq_pct) ? CMD_ENQ : CMD_DEQ,
                  narrow ? 8'($urandom_range(0, 3)) : 8'($urandom), 16'($urandom));
        made++;
      end
    end

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // drain: everything offered and taken, every result back, then margin
    while (pending_q.size() != 0 || in_valid) @(posedge clk);
    while (awaited_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("summary: %0d commands taken, %0d results: %0d enqueued, %0d dequeued,",
             accepted_n, results_n, status_seen[spq_pkg::ST_ENQ],
             status_seen[spq_pkg::ST_DEQ]);
    $display("summary: %0d empty, %0d full, input held back %0d cycles, %0d mismatches",
             status_seen[spq_pkg::ST_EMPTY], status_seen[spq_pkg::ST_FULL],
             in_stalled_n, errors);
    if (errors == 0) begin
      $display("stable_priority_queue_tb: clean");
    end else begin
      $display("stable_priority_queue_tb: errors");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("timeout with %0d results still pending", awaited_q.size());
    $display("stable_priority_queue_tb: errors");
    $finish;
  end

endmodule
